// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an implication holds at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed");

// Checks that when lhs holds, rhs holds in the following cycle.
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed");

`endif

// ===== hdl/bsb_pkg.sv =====
package bsb_pkg;
  localparam int KnotCount = 64;
  localparam int MaxDegree = 7;
  localparam int FracBits = 16;
  localparam int SlotW = $clog2(KnotCount);
  localparam int DegW = $clog2(MaxDegree + 1);
  localparam int DataW = 32;
  localparam int EpsW = 16;
  localparam int RegIdxW = 1;
  localparam int QuoW = DataW + FracBits + 2;
  localparam int QCntW = $clog2(QuoW + 1);
  localparam int MulCntW = $clog2(DataW + 2);

  localparam logic [RegIdxW-1:0] RegDegree = 1'b0;
  localparam logic [RegIdxW-1:0] RegEpsilon = 1'b1;

  localparam logic KindWrite = 1'b0;
  localparam logic KindEval = 1'b1;

  typedef enum logic [4:0] {
    StIdle, StBase0, StBase1, StBase2, StBase3,
    StLoad0, StLoad1, StLoad2, StLoad3, StLoad4, StLoad5,
    StSpan, StDiv, StDivEnd, StMul, StMulEnd, StTerm,
    StStore, StDone
  } state_t;

  typedef enum logic [1:0] {WtIdle, WtDiv, WtMul, WtFin} weigh_state_t;

  typedef struct packed {
    logic start;
    logic signed [DataW:0] num;
    logic signed [DataW:0] den;
    logic signed [DataW-1:0] lower;
  } wt_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } wt_stat_t;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [DataW+FracBits+3:0] v);
    logic signed [DataW+FracBits+3:0] mx;
    logic signed [DataW+FracBits+3:0] mn;
    mx = (DataW+FracBits+4)'($signed(32'sh7fffffff));
    mn = (DataW+FracBits+4)'($signed(32'sh80000000));
    if (v > mx) begin
      return mx[DataW-1:0];
    end else if (v < mn) begin
      return mn[DataW-1:0];
    end
    return v[DataW-1:0];
  endfunction
endpackage

// ===== hdl/bsb_if.sv =====
interface bsb_in_if;
  logic valid;
  logic ready;
  logic kind;
  logic [bsb_pkg::SlotW-1:0] knot_slot;
  logic signed [bsb_pkg::DataW-1:0] knot_value;
  logic [bsb_pkg::SlotW-1:0] point_index;
  logic signed [bsb_pkg::DataW-1:0] param_t;
  modport source (output valid, kind, knot_slot, knot_value, point_index, param_t,
                  input ready);
  modport sink (input valid, kind, knot_slot, knot_value, point_index, param_t,
                output ready);
endinterface

interface bsb_out_if;
  logic valid;
  logic ready;
  logic signed [bsb_pkg::DataW-1:0] basis_value;
  logic bad_index;
  modport source (output valid, basis_value, bad_index, input ready);
  modport sink (input valid, basis_value, bad_index, output ready);
endinterface

interface bsb_cfg_if;
  logic valid;
  logic ready;
  logic [bsb_pkg::RegIdxW-1:0] index;
  logic [bsb_pkg::DataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/bsb_ram.sv =====
module bsb_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/bsb_weigh.sv =====
// Computes sat(sat(n * 2^F / d) * lower / 2^F) with a restoring divider and
// a shift-add multiplier, one bit per cycle.
module bsb_weigh (
  input  logic clk,
  input  logic rst,
  input  bsb_pkg::wt_req_t req,
  output bsb_pkg::wt_stat_t stat,
  output logic signed [bsb_pkg::DataW-1:0] term
);
  localparam int DW = bsb_pkg::DataW;
  localparam int FB = bsb_pkg::FracBits;
  localparam int QW = bsb_pkg::QuoW;
  localparam int PW = 2 * DW;

  bsb_pkg::weigh_state_t st;
  bsb_pkg::weigh_state_t st_next;
  logic [bsb_pkg::QCntW-1:0] qcnt;
  logic [bsb_pkg::MulCntW-1:0] mcnt;
  logic [QW-1:0] dividend;
  logic [DW:0] divisor;
  logic [DW:0] rem;
  logic [QW-1:0] quo;
  logic qneg;
  logic pneg;
  logic [DW-1:0] mcand;
  logic [DW-1:0] mplier;
  logic [PW-1:0] prod;
  logic [DW+1:0] rem_sh;
  logic [DW+1:0] rem_sub;
  logic [DW:0] psum;
  logic signed [DW-1:0] ratio;
  logic [DW:0] nmag;
  logic [DW:0] dmag;
  logic signed [DW+FB+3:0] qs;
  logic signed [DW+FB+3:0] ps;

  always_comb begin
    nmag = req.num[DW] ? (DW+1)'(-req.num) : req.num;
    dmag = req.den[DW] ? (DW+1)'(-req.den) : req.den;
    rem_sh = {rem, dividend[QW-1]};
    rem_sub = rem_sh - {1'b0, divisor};
    qs = qneg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
    ratio = bsb_pkg::sat32(qs);
    psum = {1'b0, prod[PW-1:DW]} + (mplier[0] ? {1'b0, mcand} : '0);
    ps = pneg ? -$signed({4'b0000, prod[PW-1:FB]})
              : $signed({4'b0000, prod[PW-1:FB]});
  end

  always_comb begin
    st_next = st;
    case (st)
      bsb_pkg::WtIdle: if (req.start) st_next = bsb_pkg::WtDiv;
      bsb_pkg::WtDiv: if (qcnt == bsb_pkg::QCntW'(1)) st_next = bsb_pkg::WtMul;
      bsb_pkg::WtMul: if (mcnt == bsb_pkg::MulCntW'(1)) st_next = bsb_pkg::WtFin;
      bsb_pkg::WtFin: st_next = bsb_pkg::WtIdle;
      default: st_next = bsb_pkg::WtIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= bsb_pkg::WtIdle;
      stat <= '0;
    end else begin
      st <= st_next;
      stat.busy <= (st_next != bsb_pkg::WtIdle);
      stat.done <= (st == bsb_pkg::WtFin);
    end
  end

  always_ff @(posedge clk) begin
    case (st)
      bsb_pkg::WtIdle: begin
        dividend <= QW'({nmag, FB'(0)});
        divisor <= dmag;
        rem <= '0;
        quo <= '0;
        qcnt <= bsb_pkg::QCntW'(QW);
        qneg <= req.num[DW] ^ req.den[DW];
        mcand <= req.lower[DW-1] ? DW'(-req.lower) : req.lower;
        pneg <= req.lower[DW-1];
      end
      bsb_pkg::WtDiv: begin
        dividend <= {dividend[QW-2:0], 1'b0};
        qcnt <= qcnt - 1'b1;
        if (!rem_sub[DW+1]) begin
          rem <= rem_sub[DW:0];
          quo <= {quo[QW-2:0], 1'b1};
        end else begin
          rem <= rem_sh[DW:0];
          quo <= {quo[QW-2:0], 1'b0};
        end
        if (qcnt == bsb_pkg::QCntW'(1)) begin
          mcnt <= bsb_pkg::MulCntW'(DW + 1);
        end
      end
      bsb_pkg::WtMul: begin
        if (mcnt == bsb_pkg::MulCntW'(DW + 1)) begin
          mplier <= ratio[DW-1] ? DW'(-ratio) : ratio;
          pneg <= pneg ^ ratio[DW-1];
          prod <= '0;
        end else begin
          prod <= {psum, prod[DW-1:1]};
          mplier <= mplier >> 1;
        end
        mcnt <= mcnt - 1'b1;
      end
      bsb_pkg::WtFin: begin
        term <= bsb_pkg::sat32(ps);
      end
      default: ;
    endcase
  end
endmodule

// ===== hdl/bspline_basis_eval_top.sv =====
// Writes: a knot write takes effect at its accepting edge. An evaluation of degree p
// fills the degree-zero level, then works through the triangle of nodes up to degree p
// before it raises the result; a bad index raises a zero result without reading knots.
// Throughput: one request at a time; a kept term passes through the bit-serial divider
// and multiplier, while a term whose span is below epsilon skips both.
// Reset: synchronous active-high; degree 3, epsilon 7; knot table is not cleared.
`include "assert_macros.svh"
module bspline_basis_eval_top (
  input logic clk,
  input logic rst,
  bsb_in_if.sink in_ch,
  bsb_out_if.source out_ch,
  bsb_cfg_if.sink cfg
);
  localparam int DW = bsb_pkg::DataW;
  localparam int SW = bsb_pkg::SlotW;
  localparam int LW = bsb_pkg::DegW;

  logic [LW-1:0] spline_degree;
  logic [bsb_pkg::EpsW-1:0] span_epsilon;
  bsb_pkg::state_t state;
  bsb_pkg::state_t state_next;

  logic [SW-1:0] base_i;
  logic signed [DW-1:0] t;
  logic [LW-1:0] p;
  logic [LW-1:0] k;
  logic [LW-1:0] j;
  logic signed [DW-1:0] level [bsb_pkg::MaxDegree+1];
  logic signed [DW-1:0] ka, ka1, kk, kk1;
  logic signed [DW+1:0] sum;
  logic phase;
  logic we;
  logic [SW-1:0] raddr;
  logic [DW-1:0] rdata;
  bsb_pkg::wt_req_t wreq;
  bsb_pkg::wt_stat_t wstat;
  logic signed [DW-1:0] wterm;
  logic signed [DW:0] d1, d2;
  logic small1, small2;
  logic [SW:0] lim;

  bsb_ram #(.Width(DW), .Depth(bsb_pkg::KnotCount)) u_ram (
    .clk(clk), .we(we), .waddr(in_ch.knot_slot), .wdata(in_ch.knot_value),
    .raddr(raddr), .rdata(rdata)
  );

  bsb_weigh u_weigh (.clk(clk), .rst(rst), .req(wreq), .stat(wstat), .term(wterm));

  assign cfg.ready = (state == bsb_pkg::StIdle);
  assign in_ch.ready = (state == bsb_pkg::StIdle) && !out_ch.valid;
  assign we = in_ch.valid && in_ch.ready && (in_ch.kind == bsb_pkg::KindWrite);

  always_ff @(posedge clk) begin
    if (rst) begin
      spline_degree <= LW'(3);
      span_epsilon <= bsb_pkg::EpsW'(7);
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        bsb_pkg::RegDegree: spline_degree <= cfg.data[LW-1:0];
        bsb_pkg::RegEpsilon: span_epsilon <= cfg.data[bsb_pkg::EpsW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    d1 = (DW+1)'(kk) - (DW+1)'(ka);
    d2 = (DW+1)'(kk1) - (DW+1)'(ka1);
    small1 = (d1 == '0) || ((d1[DW] ? (DW+1)'(-d1) : d1) < (DW+1)'(span_epsilon));
    small2 = (d2 == '0) || ((d2[DW] ? (DW+1)'(-d2) : d2) < (DW+1)'(span_epsilon));
    lim = (SW+1)'(in_ch.point_index) + (SW+1)'(spline_degree) + 1'b1;
  end

  always_comb begin
    raddr = base_i + SW'(j);
    case (state)
      bsb_pkg::StBase0, bsb_pkg::StBase1: raddr = base_i + SW'(j);
      bsb_pkg::StBase2: raddr = base_i + SW'(j) + 1'b1;
      bsb_pkg::StLoad0, bsb_pkg::StLoad1: raddr = base_i + SW'(j);
      bsb_pkg::StLoad2: raddr = base_i + SW'(j) + SW'(k);
      bsb_pkg::StLoad3: raddr = base_i + SW'(j) + 1'b1;
      bsb_pkg::StLoad4: raddr = base_i + SW'(j) + SW'(k) + 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      bsb_pkg::StIdle:
        if (in_ch.valid && in_ch.ready && in_ch.kind == bsb_pkg::KindEval) begin
          state_next = (lim >= (SW+1)'(bsb_pkg::KnotCount)) ? bsb_pkg::StDone
                                                           : bsb_pkg::StBase0;
        end
      bsb_pkg::StBase0: state_next = bsb_pkg::StBase1;
      bsb_pkg::StBase1: state_next = bsb_pkg::StBase2;
      bsb_pkg::StBase2: state_next = bsb_pkg::StBase3;
      bsb_pkg::StBase3:
        if (j == p) begin
          state_next = (p == '0) ? bsb_pkg::StDone : bsb_pkg::StLoad0;
        end else begin
          state_next = bsb_pkg::StBase0;
        end
      bsb_pkg::StLoad0: state_next = bsb_pkg::StLoad1;
      bsb_pkg::StLoad1: state_next = bsb_pkg::StLoad2;
      bsb_pkg::StLoad2: state_next = bsb_pkg::StLoad3;
      bsb_pkg::StLoad3: state_next = bsb_pkg::StLoad4;
      bsb_pkg::StLoad4: state_next = bsb_pkg::StLoad5;
      bsb_pkg::StLoad5: state_next = bsb_pkg::StSpan;
      bsb_pkg::StSpan: state_next = bsb_pkg::StDiv;
      bsb_pkg::StDiv:
        if ((phase ? small2 : small1)) begin
          state_next = bsb_pkg::StTerm;
        end else begin
          state_next = bsb_pkg::StDivEnd;
        end
      bsb_pkg::StDivEnd: state_next = bsb_pkg::StMul;
      bsb_pkg::StMul: if (wstat.done) state_next = bsb_pkg::StMulEnd;
      bsb_pkg::StMulEnd: state_next = bsb_pkg::StTerm;
      bsb_pkg::StTerm: state_next = phase ? bsb_pkg::StStore : bsb_pkg::StDiv;
      bsb_pkg::StStore:
        if (SW'(j) + SW'(k) == SW'(p)) begin
          state_next = (k == p) ? bsb_pkg::StDone : bsb_pkg::StLoad0;
        end else begin
          state_next = bsb_pkg::StLoad0;
        end
      bsb_pkg::StDone: if (out_ch.valid && out_ch.ready) state_next = bsb_pkg::StIdle;
      default: state_next = bsb_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsb_pkg::StIdle;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    wreq.start = (state == bsb_pkg::StDivEnd);
    wreq.num = phase ? ((DW+1)'(kk1) - (DW+1)'(t)) : ((DW+1)'(t) - (DW+1)'(ka));
    wreq.den = phase ? d2 : d1;
    wreq.lower = phase ? level[j+1'b1] : level[j];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_ch.valid && out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end else if (state == bsb_pkg::StDone && state_next == bsb_pkg::StDone
                 && !out_ch.valid && !wstat.busy && phase == 1'b0) begin
      out_ch.valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      bsb_pkg::StIdle: begin
        base_i <= in_ch.point_index;
        t <= in_ch.param_t;
        p <= spline_degree;
        j <= '0;
        k <= LW'(1);
        phase <= 1'b0;
        out_ch.bad_index <= (lim >= (SW+1)'(bsb_pkg::KnotCount));
        out_ch.basis_value <= '0;
      end
      bsb_pkg::StBase2: ka <= rdata;
      bsb_pkg::StBase3: begin
        level[j] <= (ka <= t && t < $signed(rdata)) ? DW'(1 << bsb_pkg::FracBits) : '0;
        if (j == p) begin
          j <= '0;
          if (p == '0) begin
            out_ch.basis_value <= (ka <= t && t < $signed(rdata))
                                  ? DW'(1 << bsb_pkg::FracBits) : '0;
          end
        end else begin
          j <= j + 1'b1;
        end
      end
      bsb_pkg::StLoad2: ka <= rdata;
      bsb_pkg::StLoad3: kk <= rdata;
      bsb_pkg::StLoad4: ka1 <= rdata;
      bsb_pkg::StLoad5: begin
        kk1 <= rdata;
        sum <= '0;
        phase <= 1'b0;
      end
      bsb_pkg::StTerm: begin
        if (!(phase ? small2 : small1)) begin
          sum <= sum + (DW+2)'(wterm);
        end
        phase <= ~phase;
      end
      bsb_pkg::StStore: begin
        level[j] <= bsb_pkg::sat32((DW+bsb_pkg::FracBits+4)'(sum));
        if (SW'(j) + SW'(k) == SW'(p)) begin
          j <= '0;
          k <= k + 1'b1;
          if (k == p) begin
            out_ch.basis_value <= bsb_pkg::sat32((DW+bsb_pkg::FracBits+4)'(sum));
          end
        end else begin
          j <= j + 1'b1;
        end
      end
      default: ;
    endcase
  end

  `ASSERT_IMPL(a_out_needs_done, clk, rst, out_ch.valid, state == bsb_pkg::StDone)
  `ASSERT_IMPL(a_bad_zero, clk, rst, out_ch.valid && out_ch.bad_index,
               out_ch.basis_value == '0)
  `ASSERT_NEXT(a_take_clears, clk, rst, out_ch.valid && out_ch.ready,
               !out_ch.valid && state == bsb_pkg::StIdle)
endmodule
